/* src/tsd_pkg.sv */
`default_nettype none

package tsd_pkg;

  // field widths
  localparam int FlagWidth     = 16;
  localparam int RssiWidth     = 9;
  localparam int TailWidth     = 8;
  localparam int SilenceWidth  = 11;
  localparam int PowerWidth    = 7;
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 11;

  // tone status word bit positions
  localparam int BitCtc1 = 10;
  localparam int BitCtc2 = 11;
  localparam int BitDcsn = 14;
  localparam int BitDcsi = 15;

  // signal bar scaling: (rssi - 72) * 100 / 258 as (x * 812850) >> 21
  localparam logic [RssiWidth-1:0] RssiLow  = 9'd72;
  localparam logic [RssiWidth-1:0] RssiHigh = 9'd330;
  localparam logic [RssiWidth-1:0] RssiSpan = 9'd258;
  localparam int                   RecipWidth = 20;
  localparam logic [RecipWidth-1:0] BarRecip = 20'd812850;
  localparam int                   BarShift = 21;
  localparam int                   ProdWidth = RssiWidth + RecipWidth;

  // register reset values
  localparam logic [TailWidth-1:0]    TailReset    = 8'd10;
  localparam logic [SilenceWidth-1:0] SilenceReset = 11'd1000;

  // register indexes
  localparam logic [CfgIndexWidth-1:0] REG_CODE_TYPE     = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_MUTE_ENABLED  = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_MONITOR_MODE  = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_NON_FM        = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_TAIL_LIMIT    = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_SILENCE_LIMIT = 3'd5;

  typedef enum logic [1:0] {
    CODE_OFF   = 2'd0,
    CODE_CTCSS = 2'd1,
    CODE_DCS_N = 2'd2,
    CODE_DCS_I = 2'd3
  } code_type_t;

  typedef enum logic [1:0] {
    TONE_NONE = 2'd0,
    TONE_GOT  = 2'd1,
    TONE_TAIL = 2'd2
  } tone_t;

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_METER       = 3'd1,
    ACT_END_RX      = 3'd2,
    ACT_END_AUDIO   = 3'd3,
    ACT_START_AUDIO = 3'd4,
    ACT_START_RX    = 3'd5
  } action_t;

  // configuration shared by the decision logic
  typedef struct packed {
    code_type_t                code_type;
    logic                      mute_enabled;
    logic                      monitor_mode;
    logic                      non_fm_modulation;
    logic [TailWidth-1:0]      tail_limit;
    logic [SilenceWidth-1:0]   silence_limit;
  } cfg_t;

endpackage

`default_nettype wire

/* src/tsd_tone.sv */
`default_nettype none

module tsd_tone
  import tsd_pkg::*;
(
  input  wire cfg_t                 cfg,
  input  wire logic [FlagWidth-1:0] tone_flags,
  output tone_t                     tone
);

  logic code_off_open;

  assign code_off_open = (cfg.code_type == CODE_OFF) && !cfg.mute_enabled;

  // fixed priority: monitor, ctc2, ctc1, dcs-n, dcs-i, code off
  always_comb begin
    tone = TONE_NONE;
    if (cfg.monitor_mode) begin
      tone = TONE_GOT;
    end else if (tone_flags[BitCtc2]) begin
      tone = TONE_TAIL;
    end else if (tone_flags[BitCtc1] && (cfg.code_type == CODE_CTCSS)) begin
      tone = TONE_GOT;
    end else if (tone_flags[BitCtc1] && ((cfg.code_type == CODE_DCS_N) ||
                 (cfg.code_type == CODE_DCS_I) || cfg.mute_enabled)) begin
      tone = TONE_TAIL;
    end else if (tone_flags[BitDcsn] && ((cfg.code_type == CODE_DCS_I) ||
                 cfg.mute_enabled)) begin
      tone = TONE_GOT;
    end else if (tone_flags[BitDcsi] && (cfg.code_type == CODE_DCS_N)) begin
      tone = TONE_GOT;
    end else if (code_off_open) begin
      tone = TONE_GOT;
    end
  end

endmodule

`default_nettype wire

/* src/tsd_bar.sv */
`default_nettype none

module tsd_bar
  import tsd_pkg::*;
(
  input  wire logic [RssiWidth-1:0]  rssi_raw,
  output logic      [PowerWidth-1:0] power_level
);

  logic [RssiWidth-1:0] offset;
  logic [ProdWidth-1:0] prod;

  // clamp to the bar window and move to zero base
  always_comb begin
    if (rssi_raw < RssiLow) begin
      offset = '0;
    end else if (rssi_raw > RssiHigh) begin
      offset = RssiSpan;
    end else begin
      offset = rssi_raw - RssiLow;
    end
  end

  // divide by the span through a reciprocal, exact over the clamped range
  assign prod        = {{RecipWidth{1'b0}}, offset} * {{RssiWidth{1'b0}}, BarRecip};
  assign power_level = prod[BarShift +: PowerWidth];

endmodule

`default_nettype wire

/* src/tsd_track.sv */
`default_nettype none

module tsd_track
  import tsd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic enable,
  input  wire logic incoming,
  input  wire logic audio_active,
  input  wire logic meter_due,
  input  wire tone_t tone,
  input  wire cfg_t cfg,
  output action_t   action
);

  logic [TailWidth-1:0]    tail_count;
  logic [SilenceWidth-1:0] silence_count;
  logic [TailWidth-1:0]    tail_next;
  logic [SilenceWidth-1:0] silence_inc;
  logic [SilenceWidth-1:0] silence_next;
  logic                    in_limits;

  // saturating tail and silence counts
  always_comb begin
    if (tone == TONE_TAIL) begin
      tail_next = (tail_count == '1) ? tail_count : tail_count + 1'b1;
    end else begin
      tail_next = '0;
    end
    if ((tone == TONE_NONE) && (silence_count != '1)) begin
      silence_inc = silence_count + 1'b1;
    end else begin
      silence_inc = silence_count;
    end
    in_limits    = (tail_next <= cfg.tail_limit) && (silence_inc <= cfg.silence_limit);
    silence_next = in_limits ? '0 : silence_inc;
  end

  // action select
  always_comb begin
    action = ACT_NONE;
    if (!incoming) begin
      if (in_limits) begin
        if (meter_due && !audio_active) begin
          action = ACT_METER;
        end
      end else begin
        action = audio_active ? ACT_END_AUDIO : ACT_END_RX;
      end
    end else if (audio_active) begin
      action = ACT_START_AUDIO;
    end else if (((cfg.code_type == CODE_OFF) && !cfg.mute_enabled) ||
                 cfg.non_fm_modulation || (tone == TONE_GOT)) begin
      action = ACT_START_RX;
    end
  end

  // counters move only for receive-mode beats
  always_ff @(posedge clk) begin
    if (rst) begin
      tail_count    <= '0;
      silence_count <= '0;
    end else if (enable && !incoming) begin
      tail_count    <= tail_next;
      silence_count <= silence_next;
    end
  end

endmodule

`default_nettype wire

/* src/tone_squelch_decider.sv */
// an accepted input beat is held in the input register, then m_tvalid rises as it enters the result register
// throughput: one beat per cycle while m_tready does not stall the result register
// s_tready stays high while the result register drains or is free
// reset (rst, synchronous, active high): clears both valid flags and the
// tail/silence counts, and loads every configuration register with its default value
`default_nettype none

module tone_squelch_decider
  import tsd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // configuration write port
  input  wire logic                     cfg_we,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data,
  // input stream
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // s_tdata: tone_flags[15:0], rssi_raw[24:16], incoming[25],
  // audio_active[26], meter_due[27], zero[31:28]
  input  wire logic [31:0]              s_tdata,
  // result stream
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // m_tdata: tone_state[1:0], action[4:2], power_level[11:5], zero[15:12]
  output logic [15:0]                   m_tdata
);

  cfg_t                   cfg;
  logic                   in_valid;
  logic [FlagWidth-1:0]   in_flags;
  logic [RssiWidth-1:0]   in_rssi;
  logic                   in_incoming;
  logic                   in_audio;
  logic                   in_due;
  logic                   advance;
  tone_t                  tone;
  action_t                action;
  logic [PowerWidth-1:0]  bar_level;
  logic [PowerWidth-1:0]  power_next;
  tone_t                  out_tone;
  action_t                out_action;
  logic [PowerWidth-1:0]  out_power;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_type         <= CODE_OFF;
      cfg.mute_enabled      <= 1'b0;
      cfg.monitor_mode      <= 1'b0;
      cfg.non_fm_modulation <= 1'b0;
      cfg.tail_limit        <= TailReset;
      cfg.silence_limit     <= SilenceReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CODE_TYPE:     cfg.code_type         <= code_type_t'(cfg_data[1:0]);
        REG_MUTE_ENABLED:  cfg.mute_enabled      <= cfg_data[0];
        REG_MONITOR_MODE:  cfg.monitor_mode      <= cfg_data[0];
        REG_NON_FM:        cfg.non_fm_modulation <= cfg_data[0];
        REG_TAIL_LIMIT:    cfg.tail_limit        <= cfg_data[TailWidth-1:0];
        REG_SILENCE_LIMIT: cfg.silence_limit     <= cfg_data[SilenceWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshake: the input stage moves on when the result register can take it
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_flags    <= s_tdata[15:0];
      in_rssi     <= s_tdata[24:16];
      in_incoming <= s_tdata[25];
      in_audio    <= s_tdata[26];
      in_due      <= s_tdata[27];
    end
  end

  // decision logic
  tsd_tone u_tone (
    .cfg        (cfg),
    .tone_flags (in_flags),
    .tone       (tone)
  );

  tsd_track u_track (
    .clk          (clk),
    .rst          (rst),
    .enable       (advance),
    .incoming     (in_incoming),
    .audio_active (in_audio),
    .meter_due    (in_due),
    .tone         (tone),
    .cfg          (cfg),
    .action       (action)
  );

  tsd_bar u_bar (
    .rssi_raw    (in_rssi),
    .power_level (bar_level)
  );

  assign power_next = (action == ACT_METER) ? bar_level : '0;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tone   <= tone;
      out_action <= action;
      out_power  <= power_next;
    end
  end

  assign m_tdata = {4'b0000, out_power, out_action, out_tone};

endmodule

`default_nettype wire

/* src/tsd_check.sv */
`default_nettype none

module tsd_check
  import tsd_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     s_tvalid,
  input wire logic                     s_tready,
  input wire logic                     m_tvalid,
  input wire logic                     m_tready,
  input wire logic [15:0]              m_tdata
);

  // a stalled result beat holds its data
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result beat changed while stalled");

  // power bar is zero unless the beat is a meter update
  a_power_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[4:2] != ACT_METER) |-> (m_tdata[11:5] == '0))
    else $error("power level set without meter update");

  // meter updates stay within the 0..100 bar
  a_power_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[4:2] == ACT_METER) |-> (m_tdata[11:5] <= 7'd100))
    else $error("power level above full bar");

  // a result appearing on an idle output follows an input beat that passed the input register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without matching input beat");

endmodule

bind tone_squelch_decider tsd_check u_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
